// ===== design/lbbc_pkg.sv =====
`default_nettype none
package lbbc_pkg;

    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_RESIZE = 3'd1,
        OP_TOUCH  = 3'd2,
        OP_REMOVE = 3'd3,
        OP_QUERY  = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_OVERSIZE = 2'd2
    } status_t;

    localparam logic KIND_EVICT = 1'b0;
    localparam logic KIND_FINAL = 1'b1;

    localparam int CAP_W  = 25;
    localparam int SIZE_W = 24;
    localparam int ADDR_W = 32;
    localparam logic [CAP_W-1:0] CAP_RESET = 25'd1048576;

    typedef struct packed {
        logic [2:0]        op;
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
    } cmd_t;

    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
        logic [1:0]        status;
        logic              last;
    } res_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH,
        S_DISPATCH,
        S_FITCHK,
        S_LRU,
        S_EVICT,
        S_COMMIT,
        S_STAMP,
        S_RANK,
        S_RANKWR,
        S_RESP
    } bstate_t;

endpackage
`default_nettype wire

// ===== design/lbbc_front.sv =====
`default_nettype none
module lbbc_front (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  wire lbbc_pkg::cmd_t  in_cmd,
    output logic                 q_valid,
    input  wire                  q_ready,
    output lbbc_pkg::cmd_t       q_cmd
);
    import lbbc_pkg::*;

    // two-entry queue between intake and the engine
    cmd_t       mem_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = mem_reg[rptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wptr_next = push ? ~wptr_reg : wptr_reg;
        rptr_next = pop ? ~rptr_reg : rptr_reg;
        cnt_next  = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= in_cmd;
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg != 2'd3)
        else $error("queue count out of range");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> !push)
        else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd0 |-> !pop)
        else $error("pop from empty queue");

endmodule
`default_nettype wire

// ===== design/lbbc_back.sv =====
`default_nettype none
module lbbc_back #(
    parameter int ENTRIES    = 32,
    parameter int STAMP_BITS = 32
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire [lbbc_pkg::CAP_W-1:0] capacity,
    input  wire                   q_valid,
    output logic                  q_ready,
    input  wire lbbc_pkg::cmd_t   q_cmd,
    output logic                  r_valid,
    input  wire                   r_ready,
    output lbbc_pkg::res_t        r_res
);
    import lbbc_pkg::*;

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(ENTRIES);

    // entry table, one entry visited per cycle
    logic [ADDR_W-1:0]     addr_mem  [ENTRIES];
    logic [SIZE_W-1:0]     bytes_mem [ENTRIES];
    logic [STAMP_BITS-1:0] stamp_mem [ENTRIES];
    logic [ENTRIES-1:0]    valid_reg, valid_next;

    bstate_t               state_reg, state_next;
    cmd_t                  cmd_reg, cmd_next;
    logic [IW-1:0]         i_reg, i_next;
    logic [IW-1:0]         j_reg, j_next;
    logic                  hit_reg, hit_next;
    logic [IW-1:0]         hidx_reg, hidx_next;
    logic                  free_reg, free_next;
    logic [IW-1:0]         fidx_reg, fidx_next;
    logic                  best_ok_reg, best_ok_next;
    logic [IW-1:0]         best_reg, best_next;
    logic [STAMP_BITS-1:0] bstamp_reg, bstamp_next;
    logic [STAMP_BITS-1:0] nstamp_reg, nstamp_next;
    logic [CAP_W-1:0]      used_reg, used_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [CAP_W:0]        tofree_reg, tofree_next;
    logic                  inround_reg, inround_next;
    logic [IW-1:0]         sidx_reg, sidx_next;
    logic [CW-1:0]         rank_reg, rank_next;
    logic [1:0]            status_reg, status_next;
    logic [SIZE_W-1:0]     rsize_reg, rsize_next;
    logic                  keep_reg, keep_next;
    logic [SIZE_W-1:0]     oldsz_reg, oldsz_next;
    logic                  out_valid_reg, out_valid_next;
    res_t                  out_reg, out_next;

    logic [ADDR_W-1:0]     rd_addr;
    logic [SIZE_W-1:0]     rd_bytes;
    logic [STAMP_BITS-1:0] rd_stamp_i, rd_stamp_j;
    logic                  we_stamp;
    logic [IW-1:0]         ws_idx;
    logic [STAMP_BITS-1:0] ws_val;
    logic                  we_ent;
    logic [IW-1:0]         we_idx;
    logic [SIZE_W-1:0]     we_bytes;
    logic                  we_addr;
    logic [CAP_W+1:0]      after;
    logic                  fit;
    logic                  older_ji;
    logic                  cand;

    assign rd_addr    = addr_mem[i_reg];
    assign rd_bytes   = bytes_mem[i_reg];
    assign rd_stamp_i = stamp_mem[i_reg];
    assign rd_stamp_j = stamp_mem[j_reg];

    assign after    = {2'b00, used_reg} - {3'b000, oldsz_reg} + {3'b000, cmd_reg.size};
    assign fit      = (after <= {1'b0, capacity}) && !(!keep_reg && count_reg == FULL_CNT);
    assign older_ji = (rd_stamp_j < rd_stamp_i) || (rd_stamp_j == rd_stamp_i && j_reg < i_reg);
    assign cand     = valid_reg[i_reg] && !(keep_reg && i_reg == hidx_reg);

    assign r_valid = out_valid_reg;
    assign r_res   = out_reg;
    assign q_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        hit_next       = hit_reg;
        hidx_next      = hidx_reg;
        free_next      = free_reg;
        fidx_next      = fidx_reg;
        best_ok_next   = best_ok_reg;
        best_next      = best_reg;
        bstamp_next    = bstamp_reg;
        nstamp_next    = nstamp_reg;
        used_next      = used_reg;
        count_next     = count_reg;
        tofree_next    = tofree_reg;
        inround_next   = inround_reg;
        sidx_next      = sidx_reg;
        rank_next      = rank_reg;
        status_next    = status_reg;
        rsize_next     = rsize_reg;
        keep_next      = keep_reg;
        oldsz_next     = oldsz_reg;
        valid_next     = valid_reg;
        out_valid_next = out_valid_reg && !r_ready;
        out_next       = out_reg;
        we_stamp       = 1'b0;
        ws_idx         = i_reg;
        ws_val         = nstamp_reg;
        we_ent         = 1'b0;
        we_idx         = fidx_reg;
        we_bytes       = cmd_reg.size;
        we_addr        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    cmd_next     = q_cmd;
                    i_next       = '0;
                    hit_next     = 1'b0;
                    free_next    = 1'b0;
                    status_next  = ST_OK;
                    rsize_next   = '0;
                    state_next   = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (valid_reg[i_reg] && rd_addr == cmd_reg.addr && !hit_reg)
                begin
                    hit_next  = 1'b1;
                    hidx_next = i_reg;
                end
                if (!valid_reg[i_reg] && !free_reg)
                begin
                    free_next = 1'b1;
                    fidx_next = i_reg;
                end
                if (i_reg == LAST_IDX)
                    state_next = S_DISPATCH;
                else
                    i_next = i_reg + 1'b1;
            end
            S_DISPATCH:
            begin
                i_next       = hidx_reg;
                state_next   = S_RESP;
                inround_next = 1'b0;
                case (cmd_reg.op)
                    OP_INSERT, OP_RESIZE:
                    begin
                        if (cmd_reg.op == OP_RESIZE && !hit_reg)
                            status_next = ST_NOTFOUND;
                        else if ({1'b0, cmd_reg.size} > capacity)
                            status_next = ST_OVERSIZE;
                        else if (hit_reg)
                        begin
                            keep_next  = 1'b1;
                            sidx_next  = hidx_reg;
                            state_next = S_STAMP;
                        end
                        else
                        begin
                            keep_next  = 1'b0;
                            oldsz_next = '0;
                            state_next = S_FITCHK;
                        end
                    end
                    OP_TOUCH:
                    begin
                        if (!hit_reg)
                            status_next = ST_NOTFOUND;
                        else
                        begin
                            keep_next  = 1'b1;
                            sidx_next  = hidx_reg;
                            state_next = S_STAMP;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (!hit_reg)
                            status_next = ST_NOTFOUND;
                        else
                        begin
                            i_next     = hidx_reg;
                            state_next = S_COMMIT;
                        end
                    end
                    OP_QUERY:
                    begin
                        if (!hit_reg)
                            status_next = ST_NOTFOUND;
                        else
                        begin
                            i_next     = hidx_reg;
                            state_next = S_COMMIT;
                        end
                    end
                    default:
                    begin
                        state_next = S_RESP;
                    end
                endcase
            end
            S_FITCHK:
            begin
                // start of round when not inside one
                if (!inround_reg && fit)
                begin
                    i_next     = keep_reg ? hidx_reg : fidx_reg;
                    state_next = S_COMMIT;
                end
                else
                begin
                    if (!inround_reg)
                        tofree_next = {2'b00, cmd_reg.size} << 1;
                    i_next       = '0;
                    best_ok_next = 1'b0;
                    state_next   = S_LRU;
                end
            end
            S_LRU:
            begin
                if (cand && (!best_ok_reg || rd_stamp_i < bstamp_reg))
                begin
                    best_ok_next = 1'b1;
                    best_next    = i_reg;
                    bstamp_next  = rd_stamp_i;
                end
                if (i_reg == LAST_IDX)
                    state_next = S_EVICT;
                else
                    i_next = i_reg + 1'b1;
            end
            S_EVICT:
            begin
                i_next = best_reg;
                if (!best_ok_reg)
                begin
                    inround_next = 1'b0;
                    if (!inround_reg)
                    begin
                        i_next     = keep_reg ? hidx_reg : fidx_reg;
                        state_next = S_COMMIT;
                    end
                    else
                        state_next = S_FITCHK;
                end
                else if (!out_valid_reg || r_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_next.kind   = KIND_EVICT;
                    out_next.addr   = addr_mem[best_reg];
                    out_next.size   = bytes_mem[best_reg];
                    out_next.status = ST_OK;
                    out_next.last   = 1'b0;
                    tofree_next     = tofree_reg - {2'b00, bytes_mem[best_reg]};
                    used_next       = (used_reg >= {1'b0, bytes_mem[best_reg]})
                                      ? used_reg - {1'b0, bytes_mem[best_reg]} : '0;
                    valid_next[best_reg] = 1'b0;
                    count_next      = count_reg - 1'b1;
                    if (!free_reg)
                    begin
                        free_next = 1'b1;
                        fidx_next = best_reg;
                    end
                    inround_next = 1'b1;
                    if ($signed(tofree_reg - {2'b00, bytes_mem[best_reg]}) > 0)
                    begin
                        i_next       = '0;
                        best_ok_next = 1'b0;
                        state_next   = S_LRU;
                    end
                    else
                    begin
                        inround_next = 1'b0;
                        state_next   = S_FITCHK;
                    end
                end
            end
            S_COMMIT:
            begin
                state_next = S_RESP;
                case (cmd_reg.op)
                    OP_REMOVE:
                    begin
                        used_next = (used_reg >= {1'b0, rd_bytes})
                                    ? used_reg - {1'b0, rd_bytes} : '0;
                        valid_next[i_reg] = 1'b0;
                        count_next = count_reg - 1'b1;
                    end
                    OP_QUERY:
                    begin
                        rsize_next = rd_bytes;
                    end
                    default:
                    begin
                        if (keep_reg)
                        begin
                            used_next = used_reg - {1'b0, rd_bytes} + {1'b0, cmd_reg.size};
                            we_ent    = 1'b1;
                            we_idx    = hidx_reg;
                        end
                        else if (free_reg)
                        begin
                            we_ent     = 1'b1;
                            we_addr    = 1'b1;
                            we_idx     = fidx_reg;
                            valid_next[fidx_reg] = 1'b1;
                            count_next = count_reg + 1'b1;
                            used_next  = used_reg + {1'b0, cmd_reg.size};
                            sidx_next  = fidx_reg;
                            state_next = S_STAMP;
                        end
                    end
                endcase
            end
            S_STAMP:
            begin
                we_stamp    = 1'b1;
                ws_idx      = sidx_reg;
                ws_val      = nstamp_reg;
                nstamp_next = nstamp_reg + 1'b1;
                if (nstamp_next == '0)
                begin
                    i_next     = '0;
                    j_next     = '0;
                    rank_next  = '0;
                    state_next = S_RANK;
                end
                else if (keep_reg && cmd_reg.op != OP_TOUCH)
                begin
                    i_next     = sidx_reg;
                    oldsz_next = bytes_mem[sidx_reg];
                    state_next = S_FITCHK;
                end
                else
                    state_next = S_RESP;
            end
            S_RANK:
            begin
                // rank of entry i among valid entries
                if (valid_reg[j_reg] && j_reg != i_reg && older_ji)
                    rank_next = rank_reg + 1'b1;
                if (j_reg == LAST_IDX)
                    state_next = S_RANKWR;
                else
                    j_next = j_reg + 1'b1;
            end
            S_RANKWR:
            begin
                // ranks are written after the whole pass; store aside
                j_next    = '0;
                rank_next = '0;
                if (i_reg == LAST_IDX)
                begin
                    nstamp_next = STAMP_BITS'(count_reg);
                    if (keep_reg && cmd_reg.op != OP_TOUCH)
                    begin
                        i_next     = sidx_reg;
                        oldsz_next = bytes_mem[sidx_reg];
                        state_next = S_FITCHK;
                    end
                    else
                        state_next = S_RESP;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_RANK;
                end
            end
            S_RESP:
            begin
                if (!out_valid_reg || r_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_next.kind   = KIND_FINAL;
                    out_next.addr   = cmd_reg.addr;
                    out_next.size   = rsize_reg;
                    out_next.status = status_reg;
                    out_next.last   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // rank pass results held until the pass ends
    logic [CW-1:0] rank_mem [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (state_reg == S_RANKWR)
            rank_mem[i_reg] <= rank_reg;
        if (state_reg == S_RANKWR && i_reg == LAST_IDX)
        begin
            for (int k = 0; k < ENTRIES; k++)
                if (valid_reg[k])
                    stamp_mem[k] <= (IW'(k) == LAST_IDX)
                        ? STAMP_BITS'(rank_reg) : STAMP_BITS'(rank_mem[k]);
        end
        else if (we_stamp)
            stamp_mem[ws_idx] <= ws_val;
        if (we_ent)
            bytes_mem[we_idx] <= we_bytes;
        if (we_addr)
            addr_mem[we_idx] <= cmd_reg.addr;
        cmd_reg    <= cmd_next;
        j_reg      <= j_next;
        hidx_reg   <= hidx_next;
        fidx_reg   <= fidx_next;
        best_reg   <= best_next;
        bstamp_reg <= bstamp_next;
        tofree_reg <= tofree_next;
        sidx_reg   <= sidx_next;
        rank_reg   <= rank_next;
        rsize_reg  <= rsize_next;
        oldsz_reg  <= oldsz_next;
        out_reg    <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            i_reg         <= '0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
            best_ok_reg   <= 1'b0;
            nstamp_reg    <= '0;
            used_reg      <= '0;
            count_reg     <= '0;
            inround_reg   <= 1'b0;
            status_reg    <= ST_OK;
            keep_reg      <= 1'b0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            hit_reg       <= hit_next;
            free_reg      <= free_next;
            best_ok_reg   <= best_ok_next;
            nstamp_reg    <= nstamp_next;
            used_reg      <= used_next;
            count_reg     <= count_next;
            inround_reg   <= inround_next;
            status_reg    <= status_next;
            keep_reg      <= keep_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == CW'($countones(valid_reg)))
        else $error("entry count disagrees with valid bits");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !r_ready |=> out_valid_reg && $stable(out_reg))
        else $error("result dropped while stalled");
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_ready |-> state_reg == S_IDLE)
        else $error("command taken while busy");

endmodule
`default_nettype wire

// ===== design/lru_byte_budget_code_cache.sv =====
// LRU code-block cache with a byte budget. One operation is in work at a time;
// a two-entry command queue takes transfers while the engine runs. Each
// operation costs one search of the table, plus for every eviction an LRU
// scan, plus on a stamp wrap a rank pass; each of these walks the entry
// table one entry at a time. Results leave through a one-deep output
// register; an operation yields its evictions, then a final response with
// last set.
`default_nettype none
module lru_byte_budget_code_cache #(
    parameter int ENTRIES    = 32,
    parameter int STAMP_BITS = 32
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire [24:0]  capacity_bytes,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire [2:0]   op,
    input  wire [31:0]  block_addr,
    input  wire [23:0]  byte_size,
    output logic        out_valid,
    input  wire         out_ready,
    output logic        kind,
    output logic [31:0] result_addr,
    output logic [23:0] result_size,
    output logic [1:0]  status,
    output logic        last
);
    import lbbc_pkg::*;

    logic [CAP_W-1:0] cap_reg;
    cmd_t             in_cmd, q_cmd;
    logic             q_valid, q_ready;
    res_t             res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= CAP_RESET;
        else if (cfg_valid)
            cap_reg <= capacity_bytes;
    end

    assign in_cmd.op   = op;
    assign in_cmd.addr = block_addr;
    assign in_cmd.size = byte_size;

    lbbc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_cmd   (in_cmd),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_cmd    (q_cmd)
    );

    lbbc_back #(
        .ENTRIES    (ENTRIES),
        .STAMP_BITS (STAMP_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .capacity (cap_reg),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_cmd    (q_cmd),
        .r_valid  (out_valid),
        .r_ready  (out_ready),
        .r_res    (res)
    );

    assign kind        = res.kind;
    assign result_addr = res.addr;
    assign result_size = res.size;
    assign status      = res.status;
    assign last        = res.last;

endmodule
`default_nettype wire

// ===== tb/sv/tb_lru_byte_budget_code_cache.sv =====
`timescale 1ns / 1ps
module tb_lru_byte_budget_code_cache;
    import lbbc_pkg::*;

    localparam int NUM_ENTRIES = 32;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int IDLE_PCT    = 38;
    localparam int POOL_SIZE   = 40;
    localparam logic [CAP_W-1:0] CAP_MAX = 25'd16777216;

    class cache_scoreboard;
        logic [ADDR_W-1:0] addr_tab[NUM_ENTRIES];
        logic [SIZE_W-1:0] bytes_tab[NUM_ENTRIES];
        logic [31:0]       stamp_tab[NUM_ENTRIES];
        bit                valid_tab[NUM_ENTRIES];
        logic [31:0]       stamp_ctr;
        longint            used;
        int                count;
        longint            cap;
        res_t              pending[$];
        int                errors;

        function new();
            cap = CAP_RESET;
            stamp_ctr = 0;
            used = 0;
            count = 0;
            errors = 0;
            foreach (valid_tab[i]) valid_tab[i] = 0;
        endfunction

        function void push_res(logic k, logic [ADDR_W-1:0] a, logic [SIZE_W-1:0] s,
                               logic [1:0] st, logic l);
            res_t r;
            r.kind = k;
            r.addr = a;
            r.size = s;
            r.status = st;
            r.last = l;
            pending.push_back(r);
        endfunction

        function int find(logic [ADDR_W-1:0] a);
            for (int i = 0; i < NUM_ENTRIES; i++)
                if (valid_tab[i] && addr_tab[i] == a)
                    return i;
            return -1;
        endfunction

        function bit older(int a, int b);
            return stamp_tab[a] < stamp_tab[b] || (stamp_tab[a] == stamp_tab[b] && a < b);
        endfunction

        function int lru(int keep);
            int best;
            best = -1;
            for (int i = 0; i < NUM_ENTRIES; i++)
                if (valid_tab[i] && i != keep && (best < 0 || older(i, best)))
                    best = i;
            return best;
        endfunction

        function void stamp(int idx);
            logic [31:0] rank[NUM_ENTRIES];
            stamp_tab[idx] = stamp_ctr;
            stamp_ctr = stamp_ctr + 1;
            if (stamp_ctr == 0) begin
                for (int i = 0; i < NUM_ENTRIES; i++)
                begin
                    rank[i] = 0;
                    if (valid_tab[i])
                        for (int j = 0; j < NUM_ENTRIES; j++)
                            if (valid_tab[j] && j != i && older(j, i))
                                rank[i]++;
                end
                for (int i = 0; i < NUM_ENTRIES; i++)
                    if (valid_tab[i])
                        stamp_tab[i] = rank[i];
                stamp_ctr = count;
            end
        endfunction

        function bit fits(longint old_sz, longint new_sz, bit need_slot);
            if (used - old_sz + new_sz > cap)
                return 0;
            return !need_slot || count < NUM_ENTRIES;
        endfunction

        function void make_room(int keep, longint old_sz, longint new_sz, bit need_slot);
            longint to_free;
            int v;
            while (!fits(old_sz, new_sz, need_slot))
            begin
                to_free = 2 * new_sz;
                v = lru(keep);
                if (v < 0)
                    return;
                do
                begin
                    push_res(KIND_EVICT, addr_tab[v], bytes_tab[v], ST_OK, 1'b0);
                    to_free -= bytes_tab[v];
                    used = (used >= bytes_tab[v]) ? used - bytes_tab[v] : 0;
                    valid_tab[v] = 0;
                    count--;
                    v = lru(keep);
                end while (to_free > 0 && v >= 0);
            end
        endfunction

        function void note_input(logic [2:0] o, logic [ADDR_W-1:0] a, logic [SIZE_W-1:0] s);
            int idx;
            int slot;
            logic [1:0] st;
            logic [SIZE_W-1:0] rsz;
            idx = find(a);
            st = ST_OK;
            rsz = 0;
            case (o)
                OP_INSERT, OP_RESIZE:
                begin
                    if (o == OP_RESIZE && idx < 0)
                        st = ST_NOTFOUND;
                    else if (s > cap)
                        st = ST_OVERSIZE;
                    else if (idx >= 0)
                    begin
                        stamp(idx);
                        make_room(idx, bytes_tab[idx], s, 0);
                        used = (used - bytes_tab[idx] + s) & 'h1FFFFFF;
                        bytes_tab[idx] = s;
                    end
                    else
                    begin
                        make_room(-1, 0, s, 1);
                        slot = -1;
                        for (int i = NUM_ENTRIES - 1; i >= 0; i--)
                            if (!valid_tab[i])
                                slot = i;
                        if (slot >= 0)
                        begin
                            valid_tab[slot] = 1;
                            addr_tab[slot] = a;
                            bytes_tab[slot] = s;
                            count++;
                            used = (used + s) & 'h1FFFFFF;
                            stamp(slot);
                        end
                    end
                end
                OP_TOUCH:
                    if (idx < 0) st = ST_NOTFOUND; else stamp(idx);
                OP_REMOVE:
                    if (idx < 0)
                        st = ST_NOTFOUND;
                    else
                    begin
                        used = (used >= bytes_tab[idx]) ? used - bytes_tab[idx] : 0;
                        valid_tab[idx] = 0;
                        count--;
                    end
                OP_QUERY:
                    if (idx < 0) st = ST_NOTFOUND; else rsz = bytes_tab[idx];
                default: ;
            endcase
            push_res(KIND_FINAL, a, rsz, st, 1'b1);
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result addr=%h", $time, got.addr);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.kind !== want.kind)
                $display("%0t: kind exp %0d got %0d", $time, want.kind, got.kind);
            if (got.addr !== want.addr)
                $display("%0t: addr exp %h got %h", $time, want.addr, got.addr);
            if (got.size !== want.size)
                $display("%0t: size exp %0d got %0d", $time, want.size, got.size);
            if (got.status !== want.status)
                $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
            if (got.last !== want.last)
                $display("%0t: last exp %0d got %0d", $time, want.last, got.last);
            if (got !== want)
                errors++;
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CAP_W-1:0]  capacity_bytes;
    logic              in_valid;
    logic              in_ready;
    logic [2:0]        op;
    logic [ADDR_W-1:0] block_addr;
    logic [SIZE_W-1:0] byte_size;
    logic              out_valid;
    logic              out_ready;
    logic              kind;
    logic [ADDR_W-1:0] result_addr;
    logic [SIZE_W-1:0] result_size;
    logic [1:0]        status;
    logic              last;

    cache_scoreboard   sb;
    int                cycles;
    bit                steady;
    logic [ADDR_W-1:0] addr_pool[POOL_SIZE];

    lru_byte_budget_code_cache u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .capacity_bytes(capacity_bytes),
        .in_valid(in_valid), .in_ready(in_ready),
        .op(op), .block_addr(block_addr), .byte_size(byte_size),
        .out_valid(out_valid), .out_ready(out_ready),
        .kind(kind), .result_addr(result_addr), .result_size(result_size),
        .status(status), .last(last)
    );

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_lru_byte_budget_code_cache NOT OK");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            sb.check_result({kind, result_addr, result_size, status, last});

    initial
    begin
        out_ready = 0;
        forever
        begin
            @(negedge clk);
            out_ready = steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    task automatic send_cmd(logic [2:0] o, logic [ADDR_W-1:0] a, logic [SIZE_W-1:0] s);
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid = 0;
            @(negedge clk);
        end
        in_valid = 1;
        op = o;
        block_addr = a;
        byte_size = s;
        do @(posedge clk); while (!in_ready);
        sb.note_input(o, a, s);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid = 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_cap(logic [CAP_W-1:0] v);
        drain();
        @(negedge clk);
        cfg_valid = 1;
        capacity_bytes = v;
        do @(posedge clk); while (!cfg_ready);
        sb.cap = v;
        @(negedge clk);
        cfg_valid = 0;
    endtask

    task automatic rand_item(longint size_hi);
        logic [2:0]        o;
        logic [ADDR_W-1:0] a;
        logic [SIZE_W-1:0] s;
        int                r;
        r = $urandom_range(0, 99);
        if (r < 45) o = OP_INSERT;
        else if (r < 60) o = OP_RESIZE;
        else if (r < 72) o = OP_TOUCH;
        else if (r < 82) o = OP_REMOVE;
        else if (r < 95) o = OP_QUERY;
        else o = 3'($urandom_range(5, 7));
        a = ($urandom_range(0, 9) == 0) ? $urandom() : addr_pool[$urandom_range(0, POOL_SIZE-1)];
        if ($urandom_range(0, 9) == 0)
            s = SIZE_W'($urandom());
        else
            s = SIZE_W'($urandom_range(0, int'(size_hi)));
        send_cmd(o, a, s);
    endtask

    initial
    begin
        sb = new();
        cycles = 0;
        steady = 0;
        rst_n = 0;
        cfg_valid = 0;
        capacity_bytes = CAP_RESET;
        in_valid = 0;
        op = OP_INSERT;
        block_addr = 0;
        byte_size = 0;
        foreach (addr_pool[i]) addr_pool[i] = $urandom();
        addr_pool[0] = 32'h0;
        addr_pool[1] = 32'hFFFF_FFFF;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        send_cmd(OP_INSERT, 32'h0, 24'd0);
        send_cmd(OP_INSERT, 32'hFFFF_FFFF, 24'hFF_FFFF);
        send_cmd(OP_QUERY, 32'h0, 24'd0);
        send_cmd(OP_QUERY, 32'hFFFF_FFFF, 24'd0);
        send_cmd(OP_RESIZE, 32'h1234_5678, 24'd10);
        send_cmd(OP_TOUCH, 32'h1234_5678, 24'd0);
        send_cmd(OP_REMOVE, 32'h1234_5678, 24'd0);
        send_cmd(OP_INSERT, 32'hA5A5_5A5A, 24'd1000);
        send_cmd(OP_RESIZE, 32'hA5A5_5A5A, 24'd2000);
        send_cmd(OP_TOUCH, 32'hA5A5_5A5A, 24'd0);
        send_cmd(OP_QUERY, 32'hA5A5_5A5A, 24'd0);
        send_cmd(OP_INSERT, 32'h0, 24'd500);
        send_cmd(OP_REMOVE, 32'hA5A5_5A5A, 24'd0);
        send_cmd(3'd5, 32'h1, 24'd1);
        send_cmd(3'd6, 32'h2, 24'd2);
        send_cmd(3'd7, 32'h3, 24'd3);
        write_cap(CAP_MAX);
        send_cmd(OP_INSERT, 32'hFFFF_FFFF, 24'hFF_FFFF);
        send_cmd(OP_INSERT, 32'h0000_0005, 24'd1);
        send_cmd(OP_RESIZE, 32'hFFFF_FFFF, 24'hFF_FFFE);
        write_cap(25'd1);
        send_cmd(OP_INSERT, 32'h0000_0007, 24'd1);
        send_cmd(OP_INSERT, 32'h0000_0008, 24'd2);
        send_cmd(OP_INSERT, 32'h0000_0009, 24'd0);

        write_cap(25'd8192);
        for (int i = 0; i < 25; i++) rand_item(1024);
        write_cap(CAP_RESET);
        steady = 1;
        for (int i = 0; i < 25; i++) rand_item(65536);
        steady = 0;
        write_cap(25'd2048);
        for (int i = 0; i < 20; i++) rand_item(512);
        write_cap(CAP_MAX);
        for (int i = 0; i < 20; i++) rand_item(2000000);
        write_cap(25'd1);
        for (int i = 0; i < 10; i++) rand_item(1);

        drain();
        repeat (50) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb_lru_byte_budget_code_cache OK");
        else
            $display("tb_lru_byte_budget_code_cache NOT OK");
        $finish;
    end
endmodule
